// ===== sv/ofp_pkg.sv =====
// Shared types, widths and constants of the optical-flow frame parser.
`default_nettype none
package ofp_pkg;

    localparam int OFP_BYTE_W      = 8;
    localparam int OFP_FIELD_T_W   = 48;
    localparam int OFP_TIME_BITS   = 48;
    localparam int OFP_RAW_W       = 16;
    localparam int OFP_OUT_W       = 48;
    localparam int OFP_MAG_W       = 17;
    localparam int OFP_RK_W        = 26;
    localparam int OFP_M_W         = 41;
    localparam int OFP_Q_W         = 49;
    localparam int OFP_SCALE_W     = 32;
    localparam int OFP_PROD_W      = OFP_Q_W + OFP_SCALE_W;
    localparam int OFP_NUM_W       = 69;
    localparam int OFP_SCALE_SHIFT = 24;
    localparam int OFP_INTV_W      = 20;
    localparam int OFP_ADDR_W      = 5;
    localparam int OFP_IN_W        = 56;
    localparam int OFP_RES_W       = 296;

    localparam logic [OFP_BYTE_W-1:0]  OFP_HDR_BYTE   = 8'hFE;
    localparam logic [OFP_BYTE_W-1:0]  OFP_PROTO_BYTE = 8'h04;
    localparam logic [OFP_BYTE_W-1:0]  OFP_FOOT_BYTE  = 8'hAA;
    localparam logic [OFP_SCALE_W-1:0] OFP_MEGA       = 32'd1000000;
    localparam logic [OFP_INTV_W-1:0]  OFP_FIRST_RST  = 20'd50000;
    localparam logic [OFP_INTV_W-1:0]  OFP_MIN_RST    = 20'd1000;
    localparam logic [OFP_OUT_W-1:0]   OFP_POS_LIM    = 48'h7FFF_FFFF_FFFF;
    localparam logic [OFP_OUT_W-1:0]   OFP_NEG_LIM    = 48'h8000_0000_0000;

    typedef enum logic [2:0] {
        REG_FLOW_SCALE  = 3'd0,
        REG_NEGATE_X    = 3'd1,
        REG_NEGATE_Y    = 3'd2,
        REG_FIRST_INTV  = 3'd3,
        REG_MIN_INTV    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [OFP_FIELD_T_W-1:0] arrival_us;
        logic [OFP_BYTE_W-1:0]    quality;
        logic [OFP_RAW_W-1:0]     dist_mm;
        logic [OFP_RAW_W-1:0]     flow_y;
        logic [OFP_RAW_W-1:0]     flow_x;
    } t_frame;

endpackage
`default_nettype wire

// ===== sv/ofp_frame_rx.sv =====
// Byte hunter and frame assembler: shifts frame bytes in, checks footer and checksum.
`default_nettype none
module ofp_frame_rx (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_byte_valid,
    output logic                               o_byte_ready,
    input  wire logic [ofp_pkg::OFP_BYTE_W-1:0]    i_byte,
    input  wire logic [ofp_pkg::OFP_FIELD_T_W-1:0] i_time,
    output logic                               o_frame_valid,
    input  wire logic                          i_frame_ready,
    output ofp_pkg::t_frame                    o_frame
);
    import ofp_pkg::*;

    typedef logic [3:0] t_pos;

    localparam t_pos POS_HDR      = 4'd0;
    localparam t_pos POS_PROTO    = 4'd1;
    localparam t_pos POS_FIRST    = 4'd2;
    localparam t_pos POS_SUM_LAST = 4'd7;
    localparam t_pos POS_FOOTER   = 4'd10;

    t_pos                  r_pos;
    logic                  r_frm_valid;
    logic [63:0]           r_fb;
    logic [OFP_BYTE_W-1:0] r_sum;
    t_frame                r_frame;
    logic                  w_take;
    logic                  w_good;
    logic [OFP_RAW_W-1:0]  w_range;

    assign o_byte_ready  = !r_frm_valid;
    assign w_take        = i_byte_valid && !r_frm_valid;
    assign w_good        = (i_byte == OFP_FOOT_BYTE) && (r_sum == r_fb[55:48]);
    assign w_range       = r_fb[47:32] * 16'd10;
    assign o_frame_valid = r_frm_valid;
    assign o_frame       = r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_HDR;
            r_frm_valid <= 1'b0;
        end else begin
            if (r_frm_valid && i_frame_ready) begin
                r_frm_valid <= 1'b0;
            end
            if (w_take) begin
                case (r_pos)
                    POS_HDR: begin
                        if (i_byte == OFP_HDR_BYTE) r_pos <= POS_PROTO;
                    end
                    POS_PROTO: begin
                        if (i_byte == OFP_PROTO_BYTE) r_pos <= POS_FIRST;
                        else if (i_byte != OFP_HDR_BYTE) r_pos <= POS_HDR;
                    end
                    POS_FOOTER: begin
                        r_pos <= POS_HDR;
                        if (w_good) r_frm_valid <= 1'b1;
                    end
                    default: begin
                        if (r_pos > POS_FOOTER) r_pos <= POS_HDR;
                        else r_pos <= r_pos + 4'd1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && r_pos >= POS_FIRST && r_pos < POS_FOOTER) begin
            r_fb <= {i_byte, r_fb[63:8]};
            if (r_pos == POS_FIRST) r_sum <= i_byte;
            else if (r_pos <= POS_SUM_LAST) r_sum <= r_sum + i_byte;
        end
        if (w_take && r_pos == POS_FOOTER) begin
            r_frame.flow_x     <= r_fb[15:0];
            r_frame.flow_y     <= r_fb[31:16];
            r_frame.dist_mm    <= w_range;
            r_frame.quality    <= r_fb[63:56];
            r_frame.arrival_us <= i_time;
        end
    end

`ifndef NO_ASSERTIONS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_FOOTER)
        else $error("frame position past footer");
    a_frame_after_footer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_frm_valid) |-> ($past(r_pos) == POS_FOOTER) && (r_pos == POS_HDR))
        else $error("frame raised outside footer byte");
`endif

endmodule
`default_nettype wire

// ===== sv/ofp_serial_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module ofp_serial_mul #(
    parameter int WA = 49,
    parameter int WB = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WA-1:0]    i_a,
    input  wire logic [WB-1:0]    i_b,
    output logic [WA+WB-1:0]      o_prod,
    output logic                  o_busy,
    output logic                  o_done
);
    localparam int WP = WA + WB;
    localparam int CW = $clog2(WB + 1);

    logic [WA-1:0] r_a;
    logic [WP-1:0] r_p;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [WA:0]   w_sum;

    assign w_sum  = {1'b0, r_p[WP-1:WB]} + {1'b0, (r_p[0] ? r_a : {WA{1'b0}})};
    assign o_prod = r_p;
    assign o_busy = r_busy;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{WA{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= {w_sum, r_p[WB-1:1]};
        end
    end

endmodule
`default_nettype wire

// ===== sv/ofp_serial_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ofp_serial_div #(
    parameter int WN = 69,
    parameter int WD = 48
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [WN-1:0] i_num,
    input  wire logic [WD-1:0] i_den,
    output logic [WN-1:0]      o_quot,
    output logic               o_busy,
    output logic               o_done
);
    localparam int CW = $clog2(WN + 1);

    logic [WN-1:0] r_num;
    logic [WD-1:0] r_rem;
    logic [WD-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [WD:0]   w_trial;
    logic [WD:0]   w_diff;
    logic          w_ge;

    assign w_trial = {r_rem, r_num[WN-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign o_quot  = r_num;
    assign o_busy  = r_busy;
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WN);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[WD-1:0] : w_trial[WD-1:0];
            r_num <= {r_num[WN-2:0], w_ge};
        end
    end

endmodule
`default_nettype wire

// ===== sv/optical_flow_frame_parser_unit.sv =====
// Top level: configuration registers, frame sequencer, accumulators and result register.
// From the accepted footer of a good frame to m_tvalid, per axis: two shift-add passes and one
// restoring divide. Throughput: one byte per cycle; after a good footer, input holds until the
// sequencer, once idle, takes the frame.
// Reset: synchronous active low; clears hunt state, history and positions, restores registers.
`default_nettype none
module optical_flow_frame_parser_unit #(
    parameter int TIME_BITS = ofp_pkg::OFP_TIME_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // rx_byte[7:0], arrival_time_us[55:8]
    input  wire logic [ofp_pkg::OFP_IN_W-1:0]     s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // flow_x_raw[15:0], flow_y_raw[31:16], distance_mm[47:32], frame_quality[55:48],
    // speed_x_um_s[103:56], speed_y_um_s[151:104], position_x_um[199:152],
    // position_y_um[247:200], frame_time_us[295:248]
    output logic [ofp_pkg::OFP_RES_W-1:0]         m_tdata,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ofp_pkg::OFP_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import ofp_pkg::*;

    localparam int TW = (TIME_BITS < OFP_FIELD_T_W) ? TIME_BITS : OFP_FIELD_T_W;
    localparam int MP_W = OFP_MAG_W + OFP_RK_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DT, S_CLAMP, S_MAG, S_MUL1, S_ACC, S_MUL2, S_DIV, S_OUT
    } t_state;

    t_state                  r_state;
    logic [OFP_SCALE_W-1:0]  r_scale;
    logic                    r_neg_x;
    logic                    r_neg_y;
    logic [OFP_INTV_W-1:0]   r_first;
    logic [OFP_INTV_W-1:0]   r_min;
    t_frame                  r_f;
    logic [TW-1:0]           r_now;
    logic [TW-1:0]           r_prev;
    logic                    r_have;
    logic [TIME_BITS-1:0]    r_dt;
    logic [OFP_RK_W-1:0]     r_rk;
    logic [OFP_M_W-1:0]      r_m;
    logic [OFP_Q_W-1:0]      r_q;
    logic                    r_neg;
    logic                    r_axis;
    logic [OFP_OUT_W-1:0]    r_acc_x;
    logic [OFP_OUT_W-1:0]    r_acc_y;
    logic [OFP_OUT_W-1:0]    r_vel_x;
    logic [OFP_OUT_W-1:0]    r_vel_y;
    logic                    r_mul_start;
    logic                    r_div_start;
    logic                    r_ovalid;
    logic [OFP_RES_W-1:0]    r_odata;

    logic                    w_frm_valid;
    t_frame                  w_frm;
    logic                    w_frm_take;
    logic                    w_cfg_wr;
    t_reg_idx                w_idx;
    logic [TIME_BITS-1:0]    w_clamp;
    logic [OFP_RAW_W-1:0]    w_raw;
    logic [OFP_MAG_W-1:0]    w_mag;
    logic [MP_W-1:0]         w_mprod;
    logic [OFP_Q_W-1:0]      w_mul_a;
    logic [OFP_SCALE_W-1:0]  w_mul_b;
    logic [OFP_PROD_W-1:0]   w_prod;
    logic                    w_mul_busy;
    logic                    w_mul_done;
    logic [OFP_NUM_W-1:0]    w_quot;
    logic                    w_div_busy;
    logic                    w_div_done;
    logic [OFP_OUT_W-1:0]    w_acc_cur;
    logic [OFP_OUT_W+2:0]    n_dq;
    logic [OFP_OUT_W+2:0]    n_sum;
    logic [OFP_OUT_W-1:0]    n_acc;
    logic                    w_pos_over;
    logic                    w_neg_over;
    logic [OFP_OUT_W-1:0]    w_sat_mag;
    logic [OFP_OUT_W-1:0]    n_vel;
    logic                    w_oload;

    ofp_frame_rx u_rx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_valid  (s_tvalid),
        .o_byte_ready  (s_tready),
        .i_byte        (s_tdata[OFP_BYTE_W-1:0]),
        .i_time        (s_tdata[OFP_IN_W-1:OFP_BYTE_W]),
        .o_frame_valid (w_frm_valid),
        .i_frame_ready (w_frm_take),
        .o_frame       (w_frm)
    );

    ofp_serial_mul #(.WA(OFP_Q_W), .WB(OFP_SCALE_W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_prod  (w_prod),
        .o_busy  (w_mul_busy),
        .o_done  (w_mul_done)
    );

    ofp_serial_div #(.WN(OFP_NUM_W), .WD(TIME_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (w_prod[OFP_NUM_W-1:0]),
        .i_den   (r_dt),
        .o_quot  (w_quot),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done)
    );

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite;
    assign w_idx      = t_reg_idx'(paddr[OFP_ADDR_W-1:2]);
    assign w_frm_take = (r_state == S_IDLE);

    always_comb begin
        case (w_idx)
            REG_FLOW_SCALE: prdata = r_scale;
            REG_NEGATE_X:   prdata = {31'd0, r_neg_x};
            REG_NEGATE_Y:   prdata = {31'd0, r_neg_y};
            REG_FIRST_INTV: prdata = {12'd0, r_first};
            REG_MIN_INTV:   prdata = {12'd0, r_min};
            default:        prdata = 32'd0;
        endcase
    end

    assign w_clamp = (r_min == '0) ? TIME_BITS'(1) : TIME_BITS'(r_min);
    assign w_raw   = r_axis ? r_f.flow_y : r_f.flow_x;
    assign w_mag   = w_raw[OFP_RAW_W-1] ? (17'h10000 - {1'b0, w_raw}) : {1'b0, w_raw};
    assign w_mprod = {{OFP_RK_W{1'b0}}, w_mag} * {{OFP_MAG_W{1'b0}}, r_rk};
    assign w_mul_a = (r_state == S_MUL2) ? r_q : OFP_Q_W'(r_m);
    assign w_mul_b = (r_state == S_MUL2) ? OFP_MEGA : r_scale;

    assign w_acc_cur = r_axis ? r_acc_y : r_acc_x;
    assign n_dq      = r_neg ? -{2'b00, r_q} : {2'b00, r_q};
    assign n_sum     = {{3{w_acc_cur[OFP_OUT_W-1]}}, w_acc_cur} + n_dq;

    always_comb begin
        if (n_sum[OFP_OUT_W+2:OFP_OUT_W-1] == 4'b0000 ||
            n_sum[OFP_OUT_W+2:OFP_OUT_W-1] == 4'b1111) begin
            n_acc = n_sum[OFP_OUT_W-1:0];
        end else if (n_sum[OFP_OUT_W+2]) begin
            n_acc = OFP_NEG_LIM;
        end else begin
            n_acc = OFP_POS_LIM;
        end
    end

    assign w_pos_over = |w_quot[OFP_NUM_W-1:OFP_OUT_W-1];
    assign w_neg_over = (|w_quot[OFP_NUM_W-1:OFP_OUT_W]) ||
                        (w_quot[OFP_OUT_W-1] && (|w_quot[OFP_OUT_W-2:0]));

    always_comb begin
        if (r_neg) begin
            w_sat_mag = w_neg_over ? OFP_NEG_LIM : w_quot[OFP_OUT_W-1:0];
        end else begin
            w_sat_mag = w_pos_over ? OFP_POS_LIM : w_quot[OFP_OUT_W-1:0];
        end
    end

    assign n_vel   = r_neg ? -w_sat_mag : w_sat_mag;
    assign w_oload = (r_state == S_OUT) && (!r_ovalid || m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scale     <= '0;
            r_neg_x     <= 1'b0;
            r_neg_y     <= 1'b0;
            r_first     <= OFP_FIRST_RST;
            r_min       <= OFP_MIN_RST;
            r_have      <= 1'b0;
            r_prev      <= '0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_axis      <= 1'b0;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            if (w_cfg_wr) begin
                case (w_idx)
                    REG_FLOW_SCALE: r_scale <= pwdata;
                    REG_NEGATE_X:   r_neg_x <= pwdata[0];
                    REG_NEGATE_Y:   r_neg_y <= pwdata[0];
                    REG_FIRST_INTV: r_first <= pwdata[OFP_INTV_W-1:0];
                    REG_MIN_INTV:   r_min   <= pwdata[OFP_INTV_W-1:0];
                    default: ;
                endcase
            end
            if (r_ovalid && m_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_frm_valid) begin
                        r_f     <= w_frm;
                        r_now   <= w_frm.arrival_us[TW-1:0];
                        r_axis  <= 1'b0;
                        r_state <= S_DT;
                    end
                end
                S_DT: begin
                    r_dt    <= r_have ? (TIME_BITS'(r_now) - TIME_BITS'(r_prev))
                                      : TIME_BITS'(r_first);
                    r_rk    <= OFP_RK_W'({16'd0, r_f.dist_mm} * 32'd1000);
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (r_dt < w_clamp) r_dt <= w_clamp;
                    r_prev  <= r_now;
                    r_have  <= 1'b1;
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_m         <= w_mprod[OFP_M_W-1:0];
                    r_neg       <= w_raw[OFP_RAW_W-1] ^ (r_axis ? r_neg_y : r_neg_x);
                    r_mul_start <= 1'b1;
                    r_state     <= S_MUL1;
                end
                S_MUL1: begin
                    if (w_mul_done) begin
                        r_q     <= w_prod[OFP_SCALE_SHIFT +: OFP_Q_W];
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_axis) r_acc_y <= n_acc;
                    else r_acc_x <= n_acc;
                    r_mul_start <= 1'b1;
                    r_state     <= S_MUL2;
                end
                S_MUL2: begin
                    if (w_mul_done) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (r_axis) begin
                            r_vel_y <= n_vel;
                            r_state <= S_OUT;
                        end else begin
                            r_vel_x <= n_vel;
                            r_axis  <= 1'b1;
                            r_state <= S_MAG;
                        end
                    end
                end
                S_OUT: begin
                    if (w_oload) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {OFP_FIELD_T_W'(r_now), r_acc_y, r_acc_x, r_vel_y, r_vel_x,
                                     r_f.quality, r_f.dist_mm, r_f.flow_y, r_f.flow_x};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_odata;

`ifndef NO_ASSERTIONS
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_busy && w_div_busy))
        else $error("multiplier and divider busy together");
    a_dt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAG) |-> (r_dt != '0))
        else $error("zero interval reached the arithmetic");
    a_result_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(r_state == S_OUT))
        else $error("result raised outside output step");
`endif

endmodule
`default_nettype wire
